FILE: rtl/core/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types and constants for the peak track matcher.
// ----------------------------------------------------------------------------
package ptm_pkg;

	localparam int MAX_PEAKS_DEF  = 64;
	localparam int TRACK_BITS_DEF = 16;

	localparam logic OP_PEAK  = 1'b0;
	localparam logic OP_EMPTY = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [15:0] track_number;
		logic        last_in_frame;
	} ptm_peak_t;

	typedef struct packed {
		logic [5:0] prev_position;
		logic       found;
		logic       overflow;
	} ptm_match_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic wr_en;
		logic found;
	} ptm_ctl_t;

endpackage

FILE: rtl/core/ptm_cell.sv
// ----------------------------------------------------------------------------
// ptm_cell
// One slot of the track chain: holds one current and one previous track,
// matches the passing peak and hands it on to the next slot.
// ----------------------------------------------------------------------------
module ptm_cell #(
	parameter int CELL_IDX   = 0,
	parameter int IDX_W      = 6,
	parameter int CNT_W      = 7,
	parameter int TRACK_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  ptm_pkg::ptm_ctl_t      prior_ctl,
	input  logic [TRACK_BITS-1:0]  prior_track,
	input  logic [IDX_W-1:0]       prior_wr_idx,
	input  logic [CNT_W-1:0]       prior_prev_cnt,
	input  logic [IDX_W-1:0]       prior_pos,
	output ptm_pkg::ptm_ctl_t      next_ctl,
	output logic [TRACK_BITS-1:0]  next_track,
	output logic [IDX_W-1:0]       next_wr_idx,
	output logic [CNT_W-1:0]       next_prev_cnt,
	output logic [IDX_W-1:0]       next_pos
);
	import ptm_pkg::*;

	logic [TRACK_BITS-1:0] cur_q;
	logic [TRACK_BITS-1:0] prev_q;
	logic [TRACK_BITS-1:0] cur_nxt;
	logic                  hit;
	logic                  wr;
	ptm_ctl_t              ctl_nxt;
	ptm_ctl_t              ctl_q;
	logic [TRACK_BITS-1:0] track_q;
	logic [IDX_W-1:0]      wr_idx_q;
	logic [CNT_W-1:0]      prev_cnt_q;
	logic [IDX_W-1:0]      pos_q;

	always_comb begin
		hit = prior_ctl.valid && !prior_ctl.found &&
			(CNT_W'(CELL_IDX) < prior_prev_cnt) && (prev_q == prior_track);
		wr = prior_ctl.valid && prior_ctl.wr_en && (prior_wr_idx == IDX_W'(CELL_IDX));
		cur_nxt = wr ? prior_track : cur_q;
		ctl_nxt = prior_ctl;
		ctl_nxt.found = prior_ctl.found | hit;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cur_q <= cur_nxt;
			if (prior_ctl.valid && prior_ctl.last) begin
				prev_q <= cur_nxt;
			end
			track_q    <= prior_track;
			wr_idx_q   <= prior_wr_idx;
			prev_cnt_q <= prior_prev_cnt;
			pos_q      <= hit ? IDX_W'(CELL_IDX) : prior_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (advance) begin
			ctl_q <= ctl_nxt;
		end
	end

	assign next_ctl      = ctl_q;
	assign next_track    = track_q;
	assign next_wr_idx   = wr_idx_q;
	assign next_prev_cnt = prev_cnt_q;
	assign next_pos      = pos_q;

endmodule

FILE: rtl/core/ptm_admit.sv
// ----------------------------------------------------------------------------
// ptm_admit
// Frame bookkeeping at the head of the chain: keeps the current and
// previous peak counts and tags each peak with its store slot.
// ----------------------------------------------------------------------------
module ptm_admit #(
	parameter int MAX_PEAKS  = 64,
	parameter int IDX_W      = 6,
	parameter int CNT_W      = 7,
	parameter int TRACK_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   xfer,
	input  ptm_pkg::ptm_peak_t     peak,
	output ptm_pkg::ptm_ctl_t      ctl,
	output logic [TRACK_BITS-1:0]  track,
	output logic [IDX_W-1:0]       wr_idx,
	output logic [CNT_W-1:0]       prev_cnt
);
	import ptm_pkg::*;

	logic [CNT_W-1:0] cur_cnt_q;
	logic [CNT_W-1:0] prev_cnt_q;
	logic [CNT_W-1:0] cur_cnt_inc;
	logic             room;
	logic [31:0]      trk_ext;

	always_comb begin
		room        = cur_cnt_q < CNT_W'(MAX_PEAKS);
		cur_cnt_inc = cur_cnt_q + CNT_W'(room);
		trk_ext     = 32'(peak.track_number);
		track       = trk_ext[TRACK_BITS-1:0];
		wr_idx      = cur_cnt_q[IDX_W-1:0];
		prev_cnt    = prev_cnt_q;
		ctl.valid   = xfer && (peak.operation == OP_PEAK);
		ctl.last    = peak.last_in_frame;
		ctl.wr_en   = room;
		ctl.found   = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_cnt_q  <= '0;
			prev_cnt_q <= '0;
		end else if (xfer) begin
			case (peak.operation)
				OP_EMPTY: begin
					cur_cnt_q  <= '0;
					prev_cnt_q <= '0;
				end
				OP_PEAK: begin
					if (peak.last_in_frame) begin
						prev_cnt_q <= cur_cnt_inc;
						cur_cnt_q  <= '0;
					end else begin
						cur_cnt_q <= cur_cnt_inc;
					end
				end
				default: begin
					cur_cnt_q <= cur_cnt_q;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/peak_track_matcher_core.sv
// A result transfer is offered once its peak transfer has passed the slot
// cells and the result register; an empty-frame item gives none.
// Throughput: one item per cycle, through a chain of MAX_PEAKS slot cells that
// every peak walks one cell per cycle; a stalled result halts the whole chain.
// Reset: frame counts and all valid flags clear; track slots are not reset.
// ----------------------------------------------------------------------------
// peak_track_matcher_core
// Frame-to-frame track association over a chain of track slot cells.
// ----------------------------------------------------------------------------
module peak_track_matcher_core #(
	parameter int MAX_PEAKS  = ptm_pkg::MAX_PEAKS_DEF,
	parameter int TRACK_BITS = ptm_pkg::TRACK_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                peak_valid,
	output logic                peak_ready,
	input  ptm_pkg::ptm_peak_t  peak,
	output logic                match_valid,
	input  logic                match_ready,
	output ptm_pkg::ptm_match_t match
);
	import ptm_pkg::*;

	localparam int IDX_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
	localparam int CNT_W = $clog2(MAX_PEAKS + 1);

	ptm_ctl_t              ctl_c      [MAX_PEAKS+1];
	logic [TRACK_BITS-1:0] track_c    [MAX_PEAKS+1];
	logic [IDX_W-1:0]      wr_idx_c   [MAX_PEAKS+1];
	logic [CNT_W-1:0]      prev_cnt_c [MAX_PEAKS+1];
	logic [IDX_W-1:0]      pos_c      [MAX_PEAKS+1];

	logic       advance;
	logic       xfer;
	logic       match_valid_q;
	ptm_match_t match_q;
	logic [31:0] pos_ext;

	assign advance    = !match_valid_q || match_ready;
	assign peak_ready = advance;
	assign xfer       = peak_valid && advance;

	ptm_admit #(
		.MAX_PEAKS (MAX_PEAKS),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W),
		.TRACK_BITS(TRACK_BITS)
	) u_admit (
		.clk     (clk),
		.arst_n  (arst_n),
		.xfer    (xfer),
		.peak    (peak),
		.ctl     (ctl_c[0]),
		.track   (track_c[0]),
		.wr_idx  (wr_idx_c[0]),
		.prev_cnt(prev_cnt_c[0])
	);

	assign pos_c[0] = '0;

	for (genvar k = 0; k < MAX_PEAKS; k++) begin : g_cell
		ptm_cell #(
			.CELL_IDX  (k),
			.IDX_W     (IDX_W),
			.CNT_W     (CNT_W),
			.TRACK_BITS(TRACK_BITS)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.advance       (advance),
			.prior_ctl     (ctl_c[k]),
			.prior_track   (track_c[k]),
			.prior_wr_idx  (wr_idx_c[k]),
			.prior_prev_cnt(prev_cnt_c[k]),
			.prior_pos     (pos_c[k]),
			.next_ctl      (ctl_c[k+1]),
			.next_track    (track_c[k+1]),
			.next_wr_idx   (wr_idx_c[k+1]),
			.next_prev_cnt (prev_cnt_c[k+1]),
			.next_pos      (pos_c[k+1])
		);
	end

	assign pos_ext = 32'(pos_c[MAX_PEAKS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_valid_q <= 1'b0;
		end else if (advance) begin
			match_valid_q <= ctl_c[MAX_PEAKS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			match_q.prev_position <= pos_ext[5:0];
			match_q.found         <= ctl_c[MAX_PEAKS].found;
			match_q.overflow      <= !ctl_c[MAX_PEAKS].wr_en;
		end
	end

	assign match_valid = match_valid_q;
	assign match       = match_q;

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for peak_track_matcher_core. Streams peaks and
// empty-frame items through the peak channel, predicts each match result from
// a behavioral copy of both frame stores, and checks every match transfer in
// order. The run mixes directed frames, random frames of small and
// over-capacity size, unfinished frames, and several idle/stall profiles.
// ----------------------------------------------------------------------------
module tb_top;
	import ptm_pkg::*;

	localparam int MAXP = MAX_PEAKS_DEF;
	localparam logic [15:0] TRACK_MASK = 16'((32'd1 << TRACK_BITS_DEF) - 1);
	localparam int HOLD_CYCLES = 500;
	localparam int PHASE_ITEMS = 150;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       peak_valid = 1'b0;
	logic       peak_ready;
	ptm_peak_t  peak = '0;
	logic       match_valid;
	logic       match_ready = 1'b0;
	ptm_match_t match;

	ptm_peak_t   pending_peaks[$];
	ptm_match_t  expected_matches[$];
	logic [15:0] gen_prev[$];

	logic [15:0] prev_tracks [MAXP];
	logic [15:0] cur_tracks [MAXP];
	int          prev_count = 0;
	int          cur_count = 0;

	int queued_cnt = 0;
	int sent_cnt = 0;
	int err_cnt = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	peak_track_matcher_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.peak_valid  (peak_valid),
		.peak_ready  (peak_ready),
		.peak        (peak),
		.match_valid (match_valid),
		.match_ready (match_ready),
		.match       (match)
	);

	always #4 clk = ~clk;

	function automatic bit associate_peak(input ptm_peak_t p, output ptm_match_t r);
		logic [15:0] trk;
		trk = p.track_number & TRACK_MASK;
		r = '0;
		if (p.operation == OP_EMPTY) begin
			prev_count = 0;
			cur_count = 0;
			return 1'b0;
		end
		for (int j = 0; j < prev_count; j++) begin
			if (prev_tracks[j] == trk) begin
				r.prev_position = 6'(j);
				r.found = 1'b1;
				break;
			end
		end
		if (cur_count < MAXP) begin
			cur_tracks[cur_count] = trk;
			cur_count++;
		end else begin
			r.overflow = 1'b1;
		end
		if (p.last_in_frame) begin
			prev_tracks = cur_tracks;
			prev_count = cur_count;
			cur_count = 0;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_cnt++;
	endtask

	task automatic push_peak(logic [15:0] trk, logic last);
		ptm_peak_t p;
		p.operation = OP_PEAK;
		p.track_number = trk;
		p.last_in_frame = last;
		pending_peaks.push_back(p);
		queued_cnt++;
	endtask

	task automatic push_empty(logic last);
		ptm_peak_t p;
		p.operation = OP_EMPTY;
		p.track_number = 16'($urandom);
		p.last_in_frame = last;
		pending_peaks.push_back(p);
		queued_cnt++;
		gen_prev.delete();
	endtask

	// close = 0 leaves the frame open; echo replays the previous frame reversed
	task automatic add_frame(int n, bit close, bit echo);
		logic [15:0] made[$];
		logic [15:0] trk;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (echo && gen_prev.size() > i)
				trk = gen_prev[gen_prev.size() - 1 - i];
			else if (r < 50 && gen_prev.size() > 0)
				trk = gen_prev[$urandom_range(gen_prev.size() - 1)];
			else if (r < 75)
				trk = 16'($urandom_range(15));
			else
				trk = 16'($urandom);
			push_peak(trk, close && (i == n - 1));
			made.push_back(trk);
		end
		if (close)
			gen_prev = made;
	endtask

	task automatic add_random_phase();
		int start;
		int r;
		start = queued_cnt;
		while (queued_cnt - start < PHASE_ITEMS) begin
			r = $urandom_range(99);
			if (r < 4) begin
				push_empty(1'($urandom_range(1)));
			end else if (r < 9) begin
				add_frame($urandom_range(1, 6), 1'b0, 1'b0);
				push_empty(1'($urandom_range(1)));
			end else if (r < 12) begin
				add_frame($urandom_range(60, 70), 1'b1, 1'($urandom_range(1)));
			end else begin
				add_frame($urandom_range(1, 8), 1'b1, $urandom_range(99) < 20);
			end
		end
	endtask

	task automatic drain();
		while (sent_cnt != queued_cnt || expected_matches.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		ptm_match_t res;
		if (!arst_n) begin
			peak_valid <= 1'b0;
			peak <= '0;
		end else begin
			if (peak_valid && peak_ready) begin
				sent_cnt <= sent_cnt + 1;
				if (associate_peak(peak, res))
					expected_matches.push_back(res);
			end
			if (!peak_valid || peak_ready) begin
				if (pending_peaks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					peak <= pending_peaks.pop_front();
					peak_valid <= 1'b1;
				end else begin
					peak_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		ptm_match_t want;
		if (!arst_n) begin
			match_ready <= 1'b0;
		end else begin
			if (match_valid && match_ready) begin
				if (expected_matches.size() == 0) begin
					report_mismatch("result with none pending", int'(match), 0);
				end else begin
					want = expected_matches.pop_front();
					if (match.prev_position !== want.prev_position)
						report_mismatch("prev_position", int'(match.prev_position),
							int'(want.prev_position));
					if (match.found !== want.found)
						report_mismatch("found", int'(match.found), int'(want.found));
					if (match.overflow !== want.overflow)
						report_mismatch("overflow", int'(match.overflow),
							int'(want.overflow));
				end
			end
			match_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// hold the result side off long enough to back the chain up to the input
	always @(posedge clk) begin
		if (!hold_done && arst_n && sent_cnt >= 60) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		push_peak(16'h0000, 1'b1);
		push_peak(16'hFFFF, 1'b0);
		push_peak(16'h0000, 1'b0);
		push_peak(16'hFFFF, 1'b1);
		push_peak(16'hFFFF, 1'b1);
		push_peak(16'hA5A5, 1'b0);
		push_peak(16'h5A5A, 1'b1);
		push_empty(1'b1);
		push_peak(16'h5A5A, 1'b1);
		push_peak(16'h1234, 1'b0);
		push_empty(1'b0);
		push_peak(16'h1234, 1'b1);
		push_peak(16'h1234, 1'b0);
		push_peak(16'h1234, 1'b1);
		push_empty(1'b0);
		push_empty(1'b1);
		push_peak(16'h8000, 1'b1);
		push_peak(16'h0001, 1'b1);
		push_peak(16'h8000, 1'b1);

		add_frame(66, 1'b1, 1'b0);
		add_frame(64, 1'b1, 1'b1);
		add_random_phase();
		drain();

		send_idle_pct = 49;
		recv_stall_pct = 0;
		add_random_phase();
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 49;
		add_random_phase();
		drain();

		send_idle_pct = 12;
		recv_stall_pct = 12;
		add_random_phase();
		drain();

		repeat (3 * (MAXP + 1)) @(posedge clk);
		while (expected_matches.size() != 0)
			report_mismatch("result never arrived", 0, int'(expected_matches.pop_front()));
		if (err_cnt == 0)
			$display("peak_track_matcher_core regression: pass");
		else
			$display("peak_track_matcher_core regression: fail");
		$finish;
	end

	initial begin
		#3000000;
		$display("peak_track_matcher_core regression: fail");
		$finish;
	end

endmodule
